// ===== src/swce_pkg.sv =====
// ----------------------------------------------------------------------------
// Square channel package
// Operation codes, configuration register indexes and duty patterns for the
// square-wave channel with envelope and length timer.
// ----------------------------------------------------------------------------
package swce_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_WR_LOW  = 3'd1,
        OP_WR_HIGH = 3'd2,
        OP_RD_LOW  = 3'd3,
        OP_RD_HIGH = 3'd4
    } op_t;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GB_CYCLE  = 2'd0,
        CFG_ENV_STEP  = 2'd1,
        CFG_LEN_STEP  = 2'd2
    } cfg_index_t;

    localparam int CFG_DATA_W  = 21;
    localparam int GB_CYCLE_W  = 5;
    localparam int ENV_STEP_W  = 21;
    localparam int LEN_STEP_W  = 19;
    localparam int FREQ_CNT_W  = 16;
    localparam int ENV_CNT_W   = 23;
    localparam int LEN_CNT_W   = 25;

    localparam logic [GB_CYCLE_W-1:0] GB_CYCLE_RESET = 5'd4;
    localparam logic [ENV_STEP_W-1:0] ENV_STEP_RESET = 21'd262144;
    localparam logic [LEN_STEP_W-1:0] LEN_STEP_RESET = 19'd65536;

    localparam logic [11:0] PERIOD_SPAN = 12'h800;
    localparam logic [6:0]  LENGTH_SPAN = 7'd64;
    localparam logic [3:0]  VOLUME_MAX  = 4'hF;

    typedef logic [7:0] duty_mask_t;

    // Patterns for positions 0..7, position 0 in the most significant bit.
    function automatic duty_mask_t duty_mask(input logic [1:0] duty);
        duty_mask_t m;
        case (duty)
            2'd0:    m = 8'h01;
            2'd1:    m = 8'h81;
            2'd2:    m = 8'h87;
            default: m = 8'h7E;
        endcase
        return m;
    endfunction

endpackage

// ===== src/square_wave_channel_envelope.sv =====
// ----------------------------------------------------------------------------
// Square-wave channel with volume envelope and length timer
// Each input word is one CPU tick, a control halfword write or a control
// halfword read; every word yields exactly one result word.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries operation and write_data. Every accepted word
// updates the channel state in the cycle it is taken and the m_ channel then
// presents sample, read_data and triggered from an output register. One word
// is accepted per cycle for as long as the output register is empty or being
// drained, so sustained throughput is one word per cycle; the combinational
// state update with its small reload multiplications sets that figure.
// When the receiver stalls, the result is held and s_ready falls until it is
// taken; no word is lost. Reset (aresetn low at a clock edge) loads the
// configuration registers with their defaults, clears the control halfwords,
// counters and flags, and empties the output register.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while
// idle; the block does not enforce it. Writes to unused indexes are ignored.
// ----------------------------------------------------------------------------
module square_wave_channel_envelope (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [swce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_operation,
    input  logic [15:0]                      s_write_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [3:0]                       m_sample,
    output logic [15:0]                      m_read_data,
    output logic                             m_triggered
);

    function automatic logic [swce_pkg::FREQ_CNT_W-1:0] freq_load(
        input logic [10:0]                      period,
        input logic [swce_pkg::GB_CYCLE_W-1:0]  tpgc
    );
        logic [11:0] span;
        logic [16:0] prod;
        span = swce_pkg::PERIOD_SPAN - {1'b0, period};
        prod = 17'(span) * 17'(tpgc);
        return (prod == '0) ? 16'd1 : prod[15:0];
    endfunction

    function automatic logic [swce_pkg::ENV_CNT_W-1:0] env_load(
        input logic [2:0]                       pace,
        input logic [swce_pkg::ENV_STEP_W-1:0]  tpes
    );
        logic [23:0] prod;
        logic [22:0] sat;
        prod = 24'(pace) * 24'(tpes);
        sat  = prod[23] ? 23'h7FFFFF : prod[22:0];
        return (sat == '0) ? 23'd1 : sat;
    endfunction

    function automatic logic [swce_pkg::LEN_CNT_W-1:0] len_load(
        input logic [5:0]                       len,
        input logic [swce_pkg::LEN_STEP_W-1:0]  tpls
    );
        logic [6:0]  span;
        logic [25:0] prod;
        span = swce_pkg::LENGTH_SPAN - {1'b0, len};
        prod = 26'(span) * 26'(tpls);
        return (prod == '0) ? 25'd1 : prod[24:0];
    endfunction

    // Configuration
    logic [swce_pkg::GB_CYCLE_W-1:0] tpgc_reg;
    logic [swce_pkg::ENV_STEP_W-1:0] tpes_reg;
    logic [swce_pkg::LEN_STEP_W-1:0] tpls_reg;

    // Channel state
    logic [15:0] ctrl_low_reg, ctrl_low_next;
    logic [15:0] ctrl_high_reg, ctrl_high_next;
    logic        env_increase_reg, env_increase_next;
    logic [2:0]  env_pace_reg, env_pace_next;
    logic [3:0]  volume_reg, volume_next;
    logic [2:0]  duty_pos_reg, duty_pos_next;
    logic        length_expired_reg, length_expired_next;
    logic [swce_pkg::FREQ_CNT_W-1:0] freq_cnt_reg, freq_cnt_next;
    logic        freq_running_reg, freq_running_next;
    logic [swce_pkg::ENV_CNT_W-1:0]  env_cnt_reg, env_cnt_next;
    logic        env_running_reg, env_running_next;
    logic [swce_pkg::LEN_CNT_W-1:0]  len_cnt_reg, len_cnt_next;
    logic        len_running_reg, len_running_next;

    // Output register
    logic        m_valid_reg;
    logic [3:0]  m_sample_reg, sample_next;
    logic [15:0] m_read_data_reg, read_data_next;
    logic        m_triggered_reg, triggered_next;

    logic accept;
    logic [swce_pkg::FREQ_CNT_W-1:0] freq_dec, freq_reload;
    logic [swce_pkg::ENV_CNT_W-1:0]  env_dec, env_reload;
    logic [swce_pkg::LEN_CNT_W-1:0]  len_dec;
    swce_pkg::duty_mask_t            mask;
    logic                            duty_bit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign freq_dec    = freq_cnt_reg - 1'b1;
    assign env_dec     = env_cnt_reg - 1'b1;
    assign len_dec     = len_cnt_reg - 1'b1;
    assign freq_reload = freq_load(ctrl_high_reg[10:0], tpgc_reg);
    assign env_reload  = env_load(env_pace_reg, tpes_reg);

    always_comb begin
        ctrl_low_next       = ctrl_low_reg;
        ctrl_high_next      = ctrl_high_reg;
        env_increase_next   = env_increase_reg;
        env_pace_next       = env_pace_reg;
        volume_next         = volume_reg;
        duty_pos_next       = duty_pos_reg;
        length_expired_next = length_expired_reg;
        freq_cnt_next       = freq_cnt_reg;
        freq_running_next   = freq_running_reg;
        env_cnt_next        = env_cnt_reg;
        env_running_next    = env_running_reg;
        len_cnt_next        = len_cnt_reg;
        len_running_next    = len_running_reg;
        read_data_next      = '0;
        triggered_next      = 1'b0;

        case (s_operation)
            swce_pkg::OP_TICK: begin
                // The length timer goes first; if it expires, nothing else acts.
                if (len_running_reg) begin
                    len_cnt_next = len_dec;
                    if (len_dec == '0) begin
                        len_running_next    = 1'b0;
                        length_expired_next = 1'b1;
                        freq_running_next   = 1'b0;
                        env_running_next    = 1'b0;
                    end
                end
                if (freq_running_next) begin
                    if (freq_dec == '0) begin
                        duty_pos_next = duty_pos_reg + 1'b1;
                        freq_cnt_next = freq_reload;
                    end else begin
                        freq_cnt_next = freq_dec;
                    end
                end
                if (env_running_next) begin
                    env_cnt_next = env_dec;
                    if (env_dec == '0) begin
                        if (env_increase_reg && volume_reg != swce_pkg::VOLUME_MAX) begin
                            volume_next  = volume_reg + 1'b1;
                            env_cnt_next = env_reload;
                        end else if (!env_increase_reg && volume_reg != '0) begin
                            volume_next  = volume_reg - 1'b1;
                            env_cnt_next = env_reload;
                        end else begin
                            env_running_next = 1'b0;
                        end
                    end
                end
            end
            swce_pkg::OP_WR_LOW: begin
                ctrl_low_next = s_write_data;
            end
            swce_pkg::OP_WR_HIGH: begin
                ctrl_high_next = {1'b0, s_write_data[14:0]};
                triggered_next = s_write_data[15];
                if (s_write_data[15]) begin
                    env_increase_next   = ctrl_low_reg[11];
                    env_pace_next       = ctrl_low_reg[10:8];
                    volume_next         = ctrl_low_reg[15:12];
                    duty_pos_next       = '0;
                    length_expired_next = 1'b0;
                    freq_cnt_next       = freq_load(s_write_data[10:0], tpgc_reg);
                    freq_running_next   = 1'b1;
                    env_running_next    = (ctrl_low_reg[10:8] != '0);
                    env_cnt_next        = (ctrl_low_reg[10:8] != '0)
                                        ? env_load(ctrl_low_reg[10:8], tpes_reg) : '0;
                    len_running_next    = s_write_data[14];
                    len_cnt_next        = s_write_data[14]
                                        ? len_load(ctrl_low_reg[5:0], tpls_reg) : '0;
                end
            end
            swce_pkg::OP_RD_LOW: begin
                read_data_next = ctrl_low_reg;
            end
            swce_pkg::OP_RD_HIGH: begin
                read_data_next = {1'b0, ctrl_high_reg[14:0]};
            end
            default: begin
            end
        endcase

        mask        = swce_pkg::duty_mask(ctrl_low_next[7:6]);
        duty_bit    = mask[3'd7 - duty_pos_next];
        sample_next = (length_expired_next || !duty_bit) ? 4'd0 : volume_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpgc_reg <= swce_pkg::GB_CYCLE_RESET;
            tpes_reg <= swce_pkg::ENV_STEP_RESET;
            tpls_reg <= swce_pkg::LEN_STEP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                swce_pkg::CFG_GB_CYCLE: tpgc_reg <= cfg_data[swce_pkg::GB_CYCLE_W-1:0];
                swce_pkg::CFG_ENV_STEP: tpes_reg <= cfg_data[swce_pkg::ENV_STEP_W-1:0];
                swce_pkg::CFG_LEN_STEP: tpls_reg <= cfg_data[swce_pkg::LEN_STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_low_reg       <= '0;
            ctrl_high_reg      <= '0;
            env_increase_reg   <= 1'b0;
            env_pace_reg       <= '0;
            volume_reg         <= '0;
            duty_pos_reg       <= '0;
            length_expired_reg <= 1'b0;
            freq_cnt_reg       <= '0;
            freq_running_reg   <= 1'b0;
            env_cnt_reg        <= '0;
            env_running_reg    <= 1'b0;
            len_cnt_reg        <= '0;
            len_running_reg    <= 1'b0;
        end else if (accept) begin
            ctrl_low_reg       <= ctrl_low_next;
            ctrl_high_reg      <= ctrl_high_next;
            env_increase_reg   <= env_increase_next;
            env_pace_reg       <= env_pace_next;
            volume_reg         <= volume_next;
            duty_pos_reg       <= duty_pos_next;
            length_expired_reg <= length_expired_next;
            freq_cnt_reg       <= freq_cnt_next;
            freq_running_reg   <= freq_running_next;
            env_cnt_reg        <= env_cnt_next;
            env_running_reg    <= env_running_next;
            len_cnt_reg        <= len_cnt_next;
            len_running_reg    <= len_running_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // The result word is only replaced when a new input word is taken.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_sample_reg    <= sample_next;
            m_read_data_reg <= read_data_next;
            m_triggered_reg <= triggered_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_sample    = m_sample_reg;
    assign m_read_data = m_read_data_reg;
    assign m_triggered = m_triggered_reg;

endmodule
